// File: hdl/spq_pkg.sv
// Shared types, constants and codes for the strict-priority three-level queue.
`default_nettype none
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;
	localparam int NUM_LEVELS  = 3;

	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TAIL_W  = PTR_W + 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int TOT_W   = CNT_W + 2;
	localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(RAM_DEPTH);
	localparam int PAY_W   = 64;
	localparam int RAM_W   = ID_WIDTH + PAY_W;
	localparam int OUT_ID_W  = 16;
	localparam int OUT_CNT_W = 6;

	typedef enum logic [2:0] {
		OP_ENQ   = 3'd0,
		OP_SERVE = 3'd1,
		OP_DEQ   = 3'd2,
		OP_FLUSH = 3'd3,
		OP_RSTID = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One queued beat from the front to the back.
	typedef struct packed {
		logic                is_pop;
		status_t             status;
		logic [ID_WIDTH-1:0] id;
		logic [1:0]          level;
		logic [OUT_CNT_W-1:0] count;
		logic [ADDR_W-1:0]   addr;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] ram_addr(input logic [1:0] lv,
			input logic [PTR_W-1:0] slot);
		return ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
	endfunction

endpackage
`default_nettype wire

// File: hdl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/spq_front.sv
// Front end: accepts commands, keeps pointers, counts and id counter, writes entries.
`default_nettype none
module spq_front
	import spq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              stall,
	input  wire logic [2:0]        opcode,
	input  wire logic [1:0]        level,
	input  wire logic [PAY_W-1:0]  payload,
	output logic                   push,
	output cmd_t                   push_cmd,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_waddr,
	output logic [RAM_W-1:0]       ram_wdata
);

	logic [PTR_W-1:0]    head_q [NUM_LEVELS];
	logic [CNT_W-1:0]    cnt_q  [NUM_LEVELS];
	logic [ID_WIDTH-1:0] nid_q;

	logic              accept;
	logic [1:0]        tgt;
	logic              tgt_ok;
	logic [CNT_W-1:0]  cnt_sel;
	logic [PTR_W-1:0]  head_sel;
	logic [TAIL_W-1:0] tail_sum;
	logic [PTR_W-1:0]  tail;
	logic [PTR_W-1:0]  head_nxt;
	logic [TOT_W-1:0]  total;
	logic              do_enq, do_wr, do_pop, do_flush, do_rstid;

	assign accept = start && !stall;

	always_comb begin
		tgt = level;
		if (opcode == OP_SERVE) begin
			priority if (cnt_q[2] != '0) tgt = 2'd2;
			else if (cnt_q[1] != '0) tgt = 2'd1;
			else tgt = 2'd0;
		end
		tgt_ok   = (tgt != 2'd3);
		cnt_sel  = tgt_ok ? cnt_q[tgt] : '0;
		head_sel = tgt_ok ? head_q[tgt] : '0;
		tail_sum = TAIL_W'(head_sel) + TAIL_W'(cnt_sel);
		tail     = (tail_sum >= TAIL_W'(QUEUE_DEPTH))
			? PTR_W'(tail_sum - TAIL_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
		head_nxt = (TAIL_W'(head_sel) + TAIL_W'(1) == TAIL_W'(QUEUE_DEPTH))
			? '0 : PTR_W'(TAIL_W'(head_sel) + TAIL_W'(1));
		total    = TOT_W'(cnt_q[0]) + TOT_W'(cnt_q[1]) + TOT_W'(cnt_q[2]);
	end

	always_comb begin
		push     = 1'b0;
		push_cmd = '{is_pop: 1'b0, status: ST_OK, id: '0, level: '0, count: '0,
			addr: '0};
		do_enq   = 1'b0;
		do_wr    = 1'b0;
		do_pop   = 1'b0;
		do_flush = 1'b0;
		do_rstid = 1'b0;
		if (accept) begin
			unique case (opcode)
				OP_ENQ: begin
					push           = 1'b1;
					do_enq         = 1'b1;
					push_cmd.id    = nid_q;
					push_cmd.level = level;
					if (!tgt_ok) begin
						push_cmd.status = ST_FULL;
					end else if (cnt_sel == CNT_W'(QUEUE_DEPTH)) begin
						push_cmd.status = ST_FULL;
						push_cmd.count  = OUT_CNT_W'(cnt_sel);
					end else begin
						do_wr          = 1'b1;
						push_cmd.count = OUT_CNT_W'(cnt_sel + CNT_W'(1));
					end
				end
				OP_SERVE, OP_DEQ: begin
					push = 1'b1;
					if (!tgt_ok || cnt_sel == '0) begin
						push_cmd.status = ST_EMPTY;
						push_cmd.level  = (opcode == OP_DEQ) ? level : 2'd0;
					end else begin
						do_pop          = 1'b1;
						push_cmd.is_pop = 1'b1;
						push_cmd.level  = tgt;
						push_cmd.count  = OUT_CNT_W'(cnt_sel - CNT_W'(1));
						push_cmd.addr   = ram_addr(tgt, head_sel);
					end
				end
				OP_FLUSH: begin
					push           = 1'b1;
					do_flush       = 1'b1;
					push_cmd.count = OUT_CNT_W'(total);
				end
				OP_RSTID: begin
					push     = 1'b1;
					do_rstid = 1'b1;
				end
				default: begin
					// unused opcodes are dropped
				end
			endcase
		end
	end

	assign ram_we    = do_wr;
	assign ram_waddr = ram_addr(tgt, tail);
	assign ram_wdata = {nid_q, payload};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			nid_q <= ID_WIDTH'(1);
		end else begin
			if (do_rstid) begin
				nid_q <= ID_WIDTH'(1);
			end else if (do_enq) begin
				nid_q <= nid_q + ID_WIDTH'(1);
			end
			if (do_flush) begin
				for (int i = 0; i < NUM_LEVELS; i++) begin
					head_q[i] <= '0;
					cnt_q[i]  <= '0;
				end
			end else if (do_wr) begin
				cnt_q[tgt] <= cnt_sel + CNT_W'(1);
			end else if (do_pop) begin
				cnt_q[tgt]  <= cnt_sel - CNT_W'(1);
				head_q[tgt] <= head_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/spq_fifo.sv
// Two-entry command queue between front and back; flags pending pops.
`default_nettype none
module spq_fifo
	import spq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	output logic       nonempty,
	output cmd_t       head_cmd,
	output logic       full,
	output logic       pop_pending
);

	cmd_t       ent_q [2];
	logic [1:0] vld_q;
	logic [1:0] vld_nxt;
	logic [1:0] isp_q;
	logic       rd_q;
	logic       wr_q;

	assign nonempty    = |vld_q;
	assign full        = &vld_q;
	assign head_cmd    = ent_q[rd_q];
	assign pop_pending = |(vld_q & isp_q);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	// The back end drains one beat per cycle whenever the queue holds one.
	always_comb begin
		vld_nxt = vld_q;
		if (nonempty) begin
			vld_nxt[rd_q] = 1'b0;
		end
		if (push) begin
			vld_nxt[wr_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			isp_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			vld_q <= vld_nxt;
			if (nonempty) begin
				rd_q <= ~rd_q;
			end
			if (push) begin
				isp_q[wr_q] <= push_cmd.is_pop;
				wr_q        <= ~wr_q;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/spq_back.sv
// Back end: reads popped entries from the store and drives the result beat.
`default_nettype none
module spq_back
	import spq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              nonempty,
	input  wire cmd_t              head_cmd,
	output logic                   ram_re,
	output logic [ADDR_W-1:0]      ram_raddr,
	input  wire logic [RAM_W-1:0]  ram_rdata,
	output logic                   strobe,
	output logic [1:0]             status,
	output logic [OUT_ID_W-1:0]    item_id,
	output logic [PAY_W-1:0]       item_payload,
	output logic [1:0]             served_level,
	output logic [OUT_CNT_W-1:0]   entry_count
);

	logic vld_s1;
	cmd_t cmd_s1;

	assign ram_re    = nonempty && head_cmd.is_pop;
	assign ram_raddr = head_cmd.addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (nonempty) begin
			cmd_s1 <= head_cmd;
		end
	end

	assign strobe       = vld_s1;
	assign status       = cmd_s1.status;
	assign served_level = cmd_s1.level;
	assign entry_count  = cmd_s1.count;
	assign item_id      = cmd_s1.is_pop ? OUT_ID_W'(ram_rdata[RAM_W-1:PAY_W])
		: OUT_ID_W'(cmd_s1.id);
	assign item_payload = cmd_s1.is_pop ? ram_rdata[PAY_W-1:0] : '0;

endmodule
`default_nettype wire

// File: hdl/strict_priority_three_fifo_queue_core.sv
// Top level of the strict-priority three-level FIFO queue.
//
//  channel  | handshake           | fields
//  ---------+---------------------+-------------------------------------------------
//  command  | start / busy        | opcode, level, payload
//  result   | strobe (one cycle)  | status, item_id, item_payload, served_level,
//           |                     | entry_count
//
// A result beat appears once its command has passed the command queue and the back-end s1 register.
// A pop (serve or dequeue with data) holds busy until its store read issues,
// so a pop blocks the next command; others can be taken every cycle while busy is low.
// busy is also high while the two-entry command queue is full.
// The result side cannot stall. Reset clears pointers, counts and sets the id to 1.
`default_nettype none
module strict_priority_three_fifo_queue_core
	import spq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [2:0]           opcode,
	input  wire logic [1:0]           level,
	input  wire logic [PAY_W-1:0]     payload,
	output logic                      strobe,
	output logic [1:0]                status,
	output logic [OUT_ID_W-1:0]       item_id,
	output logic [PAY_W-1:0]          item_payload,
	output logic [1:0]                served_level,
	output logic [OUT_CNT_W-1:0]      entry_count
);

	logic              push;
	cmd_t              push_cmd;
	logic              nonempty;
	cmd_t              head_cmd;
	logic              full;
	logic              pop_pending;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [RAM_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [RAM_W-1:0]  ram_rdata;

	// Holding off behind a queued pop keeps a later write from landing on a
	// slot that has not been read yet.
	assign busy = full || pop_pending;

	spq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.stall     (busy),
		.opcode    (opcode),
		.level     (level),
		.payload   (payload),
		.push      (push),
		.push_cmd  (push_cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	spq_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_cmd    (push_cmd),
		.nonempty    (nonempty),
		.head_cmd    (head_cmd),
		.full        (full),
		.pop_pending (pop_pending)
	);

	spq_ram #(
		.WIDTH (RAM_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	spq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (nonempty),
		.head_cmd     (head_cmd),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.strobe       (strobe),
		.status       (status),
		.item_id      (item_id),
		.item_payload (item_payload),
		.served_level (served_level),
		.entry_count  (entry_count)
	);

endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for the strict-priority three-level queue core: random and directed commands.
`timescale 1ns / 100ps
module tb;
	import spq_pkg::*;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam int         IDLE_LIMIT     = 1000;
	localparam int         DRAIN_CYCLES   = 8;

	typedef struct {
		logic [2:0]       op;
		logic [1:0]       lv;
		logic [PAY_W-1:0] pl;
	} queue_cmd_t;

	typedef struct {
		logic [1:0]           status;
		logic [OUT_ID_W-1:0]  id;
		logic [PAY_W-1:0]     pl;
		logic [1:0]           level;
		logic [OUT_CNT_W-1:0] count;
	} queue_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [2:0]           opcode = '0;
	logic [1:0]           level = '0;
	logic [PAY_W-1:0]     payload = '0;
	logic                 busy;
	logic                 strobe;
	logic [1:0]           status;
	logic [OUT_ID_W-1:0]  item_id;
	logic [PAY_W-1:0]     item_payload;
	logic [1:0]           served_level;
	logic [OUT_CNT_W-1:0] entry_count;

	strict_priority_three_fifo_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.level        (level),
		.payload      (payload),
		.strobe       (strobe),
		.status       (status),
		.item_id      (item_id),
		.item_payload (item_payload),
		.served_level (served_level),
		.entry_count  (entry_count)
	);

	always #5 clk = ~clk;

	// Shadow copy of the three levels
	logic [PAY_W-1:0]    shadow_pay [NUM_LEVELS][QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] shadow_id  [NUM_LEVELS][QUEUE_DEPTH];
	int unsigned         shadow_head [NUM_LEVELS];
	int unsigned         shadow_fill [NUM_LEVELS];
	logic [ID_WIDTH-1:0] shadow_next_id = ID_WIDTH'(1);

	queue_cmd_t    cmd_backlog[$];
	queue_result_t awaited_results[$];
	int            mismatches = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;
	int            gap_left = 0;
	logic          taken = 1'b0;

	task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
			input logic [PAY_W-1:0] want);
		mismatches++;
		if (mismatches <= 200)
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
	endtask

	function automatic queue_result_t pop_level(input int lv);
		queue_result_t r;
		int unsigned   h;
		h = shadow_head[lv];
		r.status = ST_OK;
		r.id     = OUT_ID_W'(shadow_id[lv][h]);
		r.pl     = shadow_pay[lv][h];
		r.level  = 2'(lv);
		shadow_head[lv] = (h + 1) % QUEUE_DEPTH;
		shadow_fill[lv]--;
		r.count  = OUT_CNT_W'(shadow_fill[lv]);
		return r;
	endfunction

	// Advance the shadow queues by one command and queue up the result it causes.
	function automatic void apply_queue_cmd(input logic [2:0] op, input logic [1:0] lv,
			input logic [PAY_W-1:0] pl);
		queue_result_t r;
		int unsigned   slot;
		int unsigned   total;
		r.status = ST_OK;
		r.id     = '0;
		r.pl     = '0;
		r.level  = '0;
		r.count  = '0;
		case (op)
		OP_ENQ: begin
			r.id = OUT_ID_W'(shadow_next_id);
			shadow_next_id = shadow_next_id + 1'b1;
			r.level = lv;
			if (lv >= NUM_LEVELS) begin
				r.status = ST_FULL;
			end else if (shadow_fill[lv] >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				r.count  = OUT_CNT_W'(shadow_fill[lv]);
			end else begin
				slot = (shadow_head[lv] + shadow_fill[lv]) % QUEUE_DEPTH;
				shadow_pay[lv][slot] = pl;
				shadow_id[lv][slot]  = shadow_next_id - 1'b1;
				shadow_fill[lv]++;
				r.count = OUT_CNT_W'(shadow_fill[lv]);
			end
			awaited_results.push_back(r);
		end
		OP_SERVE: begin
			r.status = ST_EMPTY;
			for (int k = NUM_LEVELS - 1; k >= 0; k--)
				if (r.status == ST_EMPTY && shadow_fill[k] != 0)
					r = pop_level(k);
			awaited_results.push_back(r);
		end
		OP_DEQ: begin
			if (lv >= NUM_LEVELS || shadow_fill[lv] == 0) begin
				r.status = ST_EMPTY;
				r.level  = lv;
			end else begin
				r = pop_level(lv);
			end
			awaited_results.push_back(r);
		end
		OP_FLUSH: begin
			total = 0;
			for (int k = 0; k < NUM_LEVELS; k++) begin
				total += shadow_fill[k];
				shadow_fill[k] = 0;
				shadow_head[k] = 0;
			end
			r.count = OUT_CNT_W'(total);
			awaited_results.push_back(r);
		end
		OP_RSTID: begin
			shadow_next_id = ID_WIDTH'(1);
			awaited_results.push_back(r);
		end
		default: ;  // spare opcodes: no beat, no state change
		endcase
	endfunction

	// Driver: hold a command until taken, otherwise feed the next one in bursts.
	always @(negedge clk) begin
		queue_cmd_t nxt;
		logic       drive;
		drive = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !taken)) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_backlog.size() != 0) begin
				nxt = cmd_backlog.pop_front();
				drive = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 :
						(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) :
						$urandom_range(1, 8));
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
						$urandom_range(1, 20);
				end
			end
			start <= drive;
			if (drive) begin
				opcode  <= nxt.op;
				level   <= nxt.lv;
				payload <= nxt.pl;
			end else begin
				opcode  <= 3'($urandom);
				level   <= 2'($urandom);
				payload <= {$urandom, $urandom};
			end
		end
	end

	// Monitor: check result beats, record taken commands, watch for a hang.
	always @(posedge clk) begin
		queue_result_t want;
		logic          active;
		active = 1'b0;
		if (arst_n) begin
			if (strobe === 1'b1) begin
				active = 1'b1;
				if (awaited_results.size() == 0) begin
					report_mismatch("result beat with nothing expected", item_id, '0);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (item_id !== want.id)
						report_mismatch("item_id", item_id, want.id);
					if (item_payload !== want.pl)
						report_mismatch("item_payload", item_payload, want.pl);
					if (served_level !== want.level)
						report_mismatch("served_level", served_level, want.level);
					if (entry_count !== want.count)
						report_mismatch("entry_count", entry_count, want.count);
				end
			end
			if (start && busy === 1'b0) begin
				active = 1'b1;
				apply_queue_cmd(opcode, level, payload);
			end
			idle_cycles = active ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
		taken <= arst_n && start && busy === 1'b0;
	end

	function automatic void push_cmd(input logic [2:0] op, input logic [1:0] lv,
			input logic [PAY_W-1:0] pl);
		queue_cmd_t c;
		c.op = op;
		c.lv = lv;
		c.pl = pl;
		cmd_backlog.push_back(c);
	endfunction

	initial begin
		int         enq_pct;
		int         focus;
		int         roll;
		logic [1:0] lv;

		for (int k = 0; k < NUM_LEVELS; k++) begin
			shadow_head[k] = 0;
			shadow_fill[k] = 0;
		end

		// Empty queues: serve and every dequeue, including the missing level three
		push_cmd(OP_SERVE, 2'd0, '0);
		for (int k = 0; k < 4; k++)
			push_cmd(OP_DEQ, 2'(k), '1);
		push_cmd(OP_ENQ, 2'd0, '0);
		push_cmd(OP_ENQ, 2'd1, '1);
		push_cmd(OP_ENQ, 2'd2, 64'hA5A5_5A5A_F00F_0FF0);
		push_cmd(OP_ENQ, 2'd3, '1);
		push_cmd(OP_SERVE, 2'd0, '0);
		push_cmd(OP_SERVE, 2'd3, '0);
		push_cmd(OP_DEQ, 2'd0, '0);
		// Fill level one past its depth, then pop once so the tail wraps
		for (int k = 0; k <= QUEUE_DEPTH; k++)
			push_cmd(OP_ENQ, 2'd1, {$urandom, $urandom});
		push_cmd(OP_DEQ, 2'd1, '0);
		push_cmd(OP_ENQ, 2'd1, '1);
		push_cmd(OP_ENQ, 2'd1, '0);
		push_cmd(OP_FLUSH, 2'd0, '0);
		push_cmd(OP_FLUSH, 2'd2, '0);
		for (logic [2:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op != 3'd0; op++)
			push_cmd(op, 2'($urandom), {$urandom, $urandom});
		push_cmd(OP_RSTID, 2'd0, '0);
		push_cmd(OP_RSTID, 2'd0, '0);

		// Random blocks, each focused on one level and leaning toward filling, draining or neither
		for (int b = 0; b < 48; b++) begin
			case ($urandom_range(0, 2))
			0: enq_pct = 15;
			1: enq_pct = 50;
			default: enq_pct = 85;
			endcase
			focus = $urandom_range(0, 2);
			for (int i = 0; i < 40; i++) begin
				roll = $urandom_range(0, 99);
				lv = ($urandom_range(0, 9) < 7) ? 2'(focus) : 2'($urandom_range(0, 3));
				if (roll < enq_pct)
					push_cmd(OP_ENQ, lv, {$urandom, $urandom});
				else if (roll < 97)
					push_cmd($urandom_range(0, 1) ? OP_SERVE : OP_DEQ, lv,
						{$urandom, $urandom});
				else if (roll == 97)
					push_cmd(OP_FLUSH, lv, {$urandom, $urandom});
				else if (roll == 98)
					push_cmd(OP_RSTID, lv, {$urandom, $urandom});
				else
					push_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), lv,
						{$urandom, $urandom});
			end
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (cmd_backlog.size() != 0 || start || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
